@@ rtl/ncpr_pkg.sv @@
// ----------------------------------------------------------------------------
// ncpr_pkg
// Shared types, constants and helpers of the note channel pitch remapper:
// table row layout, controller commands and status, result kinds.
// ----------------------------------------------------------------------------
package ncpr_pkg;

  localparam int KEY_COUNT = 128;
  localparam int KEY_IDX_W = (KEY_COUNT > 1) ? $clog2(KEY_COUNT) : 1;

  localparam int MOD_W = 7;

  localparam logic       OP_EVENT = 1'b0;
  localparam logic       OP_LOAD  = 1'b1;

  localparam logic [7:0] STATUS_REMAP = 8'hFD;
  localparam logic [3:0] CMD_NOTE_OFF = 4'h8;
  localparam logic [3:0] CMD_NOTE_ON  = 4'h9;
  localparam logic [3:0] CMD_POLY     = 4'hA;

  localparam logic [11:0] PITCH_HIGH = 12'hFDE;
  localparam logic [11:0] MOD_HIGH   = 12'hFDB;
  localparam logic [7:0]  MOD_LOW    = 8'h01;
  localparam logic [13:0] PITCH_BIAS = 14'h2000;

  typedef logic [KEY_IDX_W-1:0] key_idx_t;

  typedef enum logic [1:0] {
    KIND_PITCH = 2'd0,
    KIND_MOD   = 2'd1,
    KIND_EVENT = 2'd2
  } kind_t;

  typedef struct packed {
    logic              operation;
    logic [7:0]        status_byte;
    logic [7:0]        event_byte;
    logic [6:0]        key;
    logic [7:0]        data_byte;
    logic [6:0]        load_key;
    logic [4:0]        load_channel;
    logic signed [13:0] load_pitch;
    logic signed [7:0] load_mod_offset;
  } item_t;

  typedef struct packed {
    logic [4:0]        channel;
    logic signed [13:0] pitch;
    logic signed [7:0] mod_offset;
    logic signed [13:0] last_pitch;
    logic [MOD_W-1:0]  last_mod;
  } row_t;

  localparam int ROW_W = $bits(row_t);

  typedef struct packed {
    logic  capture;
    logic  load_wr;
    logic  eval;
    kind_t sel;
  } dp_cmd_t;

  typedef struct packed {
    logic pitch_now;
    logic mod_now;
    logic mod_pending;
  } dp_status_t;

  function automatic key_idx_t key_index(input logic [6:0] k);
    logic [8:0] wide;
    wide = {2'b00, k} % 9'(KEY_COUNT);
    return key_idx_t'(wide);
  endfunction

endpackage

@@ rtl/ncpr_if.sv @@
// ----------------------------------------------------------------------------
// ncpr_item_if / ncpr_result_if
// Valid/ready channels carrying input items and result transactions.
// ----------------------------------------------------------------------------
interface ncpr_item_if;
  logic              valid;
  logic              ready;
  logic              operation;
  logic [7:0]        status_byte;
  logic [7:0]        event_byte;
  logic [6:0]        key;
  logic [7:0]        data_byte;
  logic [6:0]        load_key;
  logic [4:0]        load_channel;
  logic signed [13:0] load_pitch;
  logic signed [7:0] load_mod_offset;

  modport source (
    output valid, operation, status_byte, event_byte, key, data_byte,
           load_key, load_channel, load_pitch, load_mod_offset,
    input  ready
  );
  modport sink (
    input  valid, operation, status_byte, event_byte, key, data_byte,
           load_key, load_channel, load_pitch, load_mod_offset,
    output ready
  );
endinterface

interface ncpr_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] code_high;
  logic [15:0] code_low;
  logic        last;

  modport source (
    output valid, kind, code_high, code_low, last,
    input  ready
  );
  modport sink (
    input  valid, kind, code_high, code_low, last,
    output ready
  );
endinterface

@@ rtl/ncpr_ram.sv @@
// ----------------------------------------------------------------------------
// ncpr_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module ncpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic                                       re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/ncpr_datapath.sv @@
// ----------------------------------------------------------------------------
// ncpr_datapath
// Key table memory with valid bits, modulation base register, cache compare
// and result code formatting.
// ----------------------------------------------------------------------------
module ncpr_datapath import ncpr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  item_t            item,
  input  dp_cmd_t          cmd,
  input  logic             cfg_we,
  input  logic [MOD_W-1:0] cfg_data,
  output dp_status_t       status,
  output logic [15:0]      code_high,
  output logic [15:0]      code_low
);

  logic [MOD_W-1:0]   modulation_base;
  logic [KEY_COUNT-1:0] row_valid;

  logic [7:0] ev_status;
  logic [7:0] ev_byte;
  logic [6:0] ev_key;
  logic [7:0] ev_data;
  key_idx_t   ev_idx;
  logic       rd_valid;

  logic [15:0] pitch_low;
  logic [15:0] mod_low;
  logic [15:0] event_high;
  logic [3:0]  chan;
  logic        mod_pending;

  logic             ram_we;
  key_idx_t         ram_waddr;
  row_t             ram_wdata;
  logic [ROW_W-1:0] ram_rdata;

  row_t        row;
  logic        is_remap;
  logic [4:0]  chan_dec;
  logic [3:0]  chan_now;
  logic [13:0] pv;
  logic [8:0]  mod_sum;
  logic        pitch_diff;
  logic        mod_diff;

  ncpr_ram #(
    .WIDTH (ROW_W),
    .DEPTH (KEY_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.capture),
    .raddr (key_index(item.key)),
    .rdata (ram_rdata)
  );

  // unwritten rows read as zero
  always_comb begin
    row        = rd_valid ? row_t'(ram_rdata) : '0;
    is_remap   = (ev_status == STATUS_REMAP) &&
                 (ev_byte[7:4] inside {CMD_NOTE_OFF, CMD_NOTE_ON, CMD_POLY});
    chan_dec   = row.channel - 5'd1;
    chan_now   = chan_dec[3:0];
    pv         = row.pitch ^ PITCH_BIAS;
    mod_sum    = {2'b00, modulation_base} + {row.mod_offset[7], row.mod_offset};
    pitch_diff = is_remap && (row.pitch != row.last_pitch);
    mod_diff   = is_remap && (mod_sum != {2'b00, row.last_mod});
  end

  always_comb begin
    ram_we    = cmd.load_wr || (cmd.eval && is_remap);
    ram_waddr = cmd.load_wr ? key_index(item.load_key) : ev_idx;
    if (cmd.load_wr) begin
      ram_wdata = '{channel:    item.load_channel,
                    pitch:      item.load_pitch,
                    mod_offset: item.load_mod_offset,
                    last_pitch: '0,
                    last_mod:   '0};
    end else begin
      ram_wdata = '{channel:    row.channel,
                    pitch:      row.pitch,
                    mod_offset: row.mod_offset,
                    last_pitch: row.pitch,
                    last_mod:   mod_sum[MOD_W-1:0]};
    end
  end

  always_comb begin
    status.pitch_now   = pitch_diff;
    status.mod_now     = mod_diff;
    status.mod_pending = mod_pending;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      modulation_base <= '0;
      row_valid       <= '0;
    end else begin
      if (cfg_we) begin
        modulation_base <= cfg_data;
      end
      if (ram_we) begin
        row_valid[ram_waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ev_status <= item.status_byte;
      ev_byte   <= item.event_byte;
      ev_key    <= item.key;
      ev_data   <= item.data_byte;
      ev_idx    <= key_index(item.key);
      rd_valid  <= row_valid[key_index(item.key)];
    end
    if (cmd.eval) begin
      pitch_low   <= {2'b00, pv[6:1], 1'b0, pv[13:7]};
      mod_low     <= {MOD_LOW, 1'b0, mod_sum[MOD_W-1:0]};
      event_high  <= {ev_status, is_remap ? {ev_byte[7:4], chan_now} : ev_byte};
      chan        <= chan_now;
      mod_pending <= mod_diff;
    end
  end

  always_comb begin
    case (cmd.sel)
      KIND_PITCH: begin
        code_high = {PITCH_HIGH, chan};
        code_low  = pitch_low;
      end
      KIND_MOD: begin
        code_high = {MOD_HIGH, chan};
        code_low  = mod_low;
      end
      KIND_EVENT: begin
        code_high = event_high;
        code_low  = {1'b0, ev_key, ev_data};
      end
      default: begin
        code_high = event_high;
        code_low  = {1'b0, ev_key, ev_data};
      end
    endcase
  end

endmodule

@@ rtl/ncpr_ctrl.sv @@
// ----------------------------------------------------------------------------
// ncpr_ctrl
// Sequencer: takes an item; for an event item, evaluates it and presents its
// one to three result transactions in order.
// ----------------------------------------------------------------------------
module ncpr_ctrl import ncpr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  input  logic       item_op,
  output logic       item_ready,
  output logic       result_valid,
  input  logic       result_ready,
  output logic       result_last,
  output kind_t      result_kind,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_PITCH,
    S_MOD,
    S_EVENT
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    state_next   = state;
    item_ready   = 1'b0;
    result_valid = 1'b0;
    result_last  = 1'b0;
    cmd          = '{capture: 1'b0, load_wr: 1'b0, eval: 1'b0, sel: KIND_EVENT};
    case (state)
      S_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          if (item_op == OP_LOAD) begin
            cmd.load_wr = 1'b1;
          end else begin
            cmd.capture = 1'b1;
            state_next  = S_EVAL;
          end
        end
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        if (status.pitch_now) begin
          state_next = S_PITCH;
        end else if (status.mod_now) begin
          state_next = S_MOD;
        end else begin
          state_next = S_EVENT;
        end
      end
      S_PITCH: begin
        result_valid = 1'b1;
        cmd.sel      = KIND_PITCH;
        if (result_ready) begin
          state_next = status.mod_pending ? S_MOD : S_EVENT;
        end
      end
      S_MOD: begin
        result_valid = 1'b1;
        cmd.sel      = KIND_MOD;
        if (result_ready) begin
          state_next = S_EVENT;
        end
      end
      S_EVENT: begin
        result_valid = 1'b1;
        result_last  = 1'b1;
        cmd.sel      = KIND_EVENT;
        if (result_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    result_kind = cmd.sel;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ rtl/note_channel_pitch_remapper_unit.sv @@
// ----------------------------------------------------------------------------
// note_channel_pitch_remapper_unit
// Remaps note events to per-key channels, preceded by pitch-bend and
// modulation codes when the per-key cache differs; loads key tables.
// ----------------------------------------------------------------------------
// load item: written to the table on acceptance, no result transaction
// event item: first result after the registered table read and evaluation
//   state with the cache update, then one per cycle while taken; next item
//   accepted after the last result
// reset: synchronous; clears the sequencer, the per-key valid bits (all
//   table entries read as zero) and modulation_base, no clearing pass
module note_channel_pitch_remapper_unit import ncpr_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  ncpr_item_if.sink        item,
  ncpr_result_if.source    result,
  input  logic             cfg_we,
  input  logic [MOD_W-1:0] cfg_data
);

  item_t      item_bus;
  dp_cmd_t    cmd;
  dp_status_t status;
  kind_t      kind;

  always_comb begin
    item_bus = '{operation:       item.operation,
                 status_byte:     item.status_byte,
                 event_byte:      item.event_byte,
                 key:             item.key,
                 data_byte:       item.data_byte,
                 load_key:        item.load_key,
                 load_channel:    item.load_channel,
                 load_pitch:      item.load_pitch,
                 load_mod_offset: item.load_mod_offset};
  end

  ncpr_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item.valid),
    .item_op      (item.operation),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .result_last  (result.last),
    .result_kind  (kind),
    .status       (status),
    .cmd          (cmd)
  );

  ncpr_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .item      (item_bus),
    .cmd       (cmd),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .status    (status),
    .code_high (result.code_high),
    .code_low  (result.code_low)
  );

  assign result.kind = kind;

endmodule
